FILE: rtl/led_pattern_engine_macros.svh
// ---------------------------------------------------------------------------
// led_pattern_engine_macros
// Assertion macros shared by the LED pattern engine RTL.
// ---------------------------------------------------------------------------
`ifndef LED_PATTERN_ENGINE_MACROS_SVH
`define LED_PATTERN_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("led_pattern_engine assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LPE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("led_pattern_engine assertion failed");

`endif

FILE: rtl/lpe_pkg.sv
// ---------------------------------------------------------------------------
// lpe_pkg
// Field types and codes of the LED pattern engine.
// ---------------------------------------------------------------------------
package lpe_pkg;

	typedef logic [1:0]  opcode_t;
	typedef logic [2:0]  led_t;
	typedef logic [1:0]  mode_t;
	typedef logic [15:0] word_t;
	typedef logic [4:0]  seqlen_t;
	typedef logic [3:0]  stepidx_t;
	typedef logic [7:0]  pins_t;
	typedef logic [31:0] time_t;

	localparam opcode_t OP_TICK = 2'd0;
	localparam opcode_t OP_SET  = 2'd1;
	localparam opcode_t OP_LOAD = 2'd2;

	localparam mode_t MODE_OFF    = 2'd0;
	localparam mode_t MODE_ON     = 2'd1;
	localparam mode_t MODE_BLINK  = 2'd2;
	localparam mode_t MODE_CUSTOM = 2'd3;

	localparam pins_t PINS_ALL_OFF   = 8'hFF;
	localparam word_t REFRESH_RESET  = 16'd100;

endpackage

FILE: rtl/led_pattern_engine.sv
// ---------------------------------------------------------------------------
// led_pattern_engine
// Per-LED off/on/blink/custom pattern engine driving an active-low pin byte.
// Set and load words, and ticks that do not refresh, are taken while idle and leave it idle.
// A refreshing tick walks the LEDs: off/on in the eval step, custom through a table read step,
// blink through the divider (one divider bit per cycle), then posts; the post waits while a byte is unread.
// Reset clears the step table, 1 entry/cycle, all NUM_LEDS*2**clog2(MAX_STEPS) entries.
// ---------------------------------------------------------------------------
`include "led_pattern_engine_macros.svh"

module led_pattern_engine #(
	parameter int NUM_LEDS  = 8,
	parameter int MAX_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lpe_pkg::word_t    cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpe_pkg::opcode_t  opcode,
	input  lpe_pkg::led_t     led,
	input  lpe_pkg::mode_t    mode,
	input  lpe_pkg::word_t    blink_period_ms,
	input  lpe_pkg::seqlen_t  sequence_length,
	input  lpe_pkg::stepidx_t step_index,
	input  logic              step_lit,
	input  lpe_pkg::word_t    step_duration_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output lpe_pkg::pins_t    pin_byte
);
	import lpe_pkg::*;

	localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int POS_W     = $clog2(MAX_STEPS);
	localparam int STRIDE    = 2 ** POS_W;
	localparam int MEM_DEPTH = NUM_LEDS * STRIDE;
	localparam int MEM_AW    = LED_W + POS_W;
	localparam int LEN_W     = $clog2(MAX_STEPS + 1);
	localparam int IX_W      = ((POS_W > 4) ? POS_W : 4) + 1;
	localparam int LX_W      = (LEN_W > 5) ? LEN_W : 5;
	localparam pins_t LOW_MASK = pins_t'((1 << NUM_LEDS) - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_CUST  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]       state_q;
	time_t            time_q;
	word_t            rcnt_q;
	word_t            period_q;
	pins_t            pin_image_q;
	logic             out_valid_q;
	pins_t            pin_byte_q;
	mode_t            mode_q  [NUM_LEDS];
	word_t            blink_q [NUM_LEDS];
	logic [LEN_W-1:0] len_q   [NUM_LEDS];
	logic [POS_W-1:0] pos_q   [NUM_LEDS];
	time_t            dl_q    [NUM_LEDS];
	logic [LED_W-1:0] led_cnt_q;
	logic [4:0]       bit_q;
	logic [14:0]      rem_q;
	logic [MEM_AW-1:0] clr_q;
	logic [POS_W-1:0] npos_q;
	logic             adv_q;

	// step table: {lit, duration}
	logic [16:0]      mem_q [MEM_DEPTH];
	logic [16:0]      rd_q;

	logic              accept;
	logic              led_ok;
	logic              idx_ok;
	logic [LED_W-1:0]  led_ix;
	logic [IX_W-1:0]   idx_ext;
	logic [LX_W-1:0]   seq_ext;
	logic [LX_W-1:0]   len_sat;
	logic [16:0]       cnt_next;
	word_t             eff_period;
	logic              hit;
	mode_t             cur_mode;
	logic [14:0]       half;
	logic [LEN_W-1:0]  cur_len;
	logic [POS_W-1:0]  cur_pos;
	logic [LEN_W:0]    pos_inc;
	logic [POS_W-1:0]  npos;
	logic [15:0]       r_sh;
	time_t             add_a;
	time_t             add_b;
	logic              add_c;
	logic [32:0]       sum_w;
	logic              carry;
	logic              fin;
	logic              fin_lit;
	logic              last_led;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [16:0]       mem_wdata;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_raddr;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign pin_byte  = pin_byte_q;

	// input decode
	assign led_ok  = ({1'b0, led} < 4'(NUM_LEDS));
	assign led_ix  = led[LED_W-1:0];
	assign idx_ext = IX_W'(step_index);
	assign idx_ok  = (idx_ext < IX_W'(MAX_STEPS));
	assign seq_ext = LX_W'(sequence_length);
	assign len_sat = (seq_ext > LX_W'(MAX_STEPS)) ? LX_W'(MAX_STEPS) : seq_ext;

	assign cnt_next   = 17'(rcnt_q) + 17'd1;
	assign eff_period = (period_q == '0) ? 16'd1 : period_q;
	assign hit        = (cnt_next >= 17'(eff_period));

	// selected LED
	assign cur_mode = mode_q[led_cnt_q];
	assign half     = blink_q[led_cnt_q][15:1];
	assign cur_len  = len_q[led_cnt_q];
	assign cur_pos  = pos_q[led_cnt_q];
	assign last_led = (led_cnt_q == LED_W'(NUM_LEDS - 1));
	assign r_sh     = {rem_q, time_q[bit_q]};

	// shared adder: increment, compare (a + ~b + 1), divider step, deadline add
	always_comb begin
		add_a = '0;
		add_b = '0;
		add_c = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				add_a = time_q;
				add_c = 1'b1;
			end
			ST_EVAL: begin
				add_a = time_q;
				add_b = ~dl_q[led_cnt_q];
				add_c = 1'b1;
			end
			ST_DIV: begin
				add_a = 32'(r_sh);
				add_b = ~32'(half);
				add_c = 1'b1;
			end
			ST_CUST: begin
				add_a = time_q;
				add_b = 32'(rd_q[15:0]);
			end
			default: begin
			end
		endcase
	end

	assign sum_w = {1'b0, add_a} + {1'b0, add_b} + 33'(add_c);
	assign carry = sum_w[32];

	// custom step advance; position always stays below a nonzero length
	assign pos_inc = (LEN_W + 1)'(cur_pos) + (LEN_W + 1)'(1);
	assign npos    = carry ? ((pos_inc == (LEN_W + 1)'(cur_len)) ? '0 : pos_inc[POS_W-1:0])
			: cur_pos;

	always_comb begin
		fin     = 1'b0;
		fin_lit = 1'b0;
		unique case (state_q)
			ST_EVAL: begin
				unique case (cur_mode)
					MODE_OFF:    fin = 1'b1;
					MODE_ON: begin
						fin     = 1'b1;
						fin_lit = 1'b1;
					end
					MODE_BLINK:  fin = (half == '0);
					MODE_CUSTOM: fin = (cur_len == '0);
					default:     fin = 1'b1;
				endcase
			end
			ST_DIV: begin
				fin     = (bit_q == '0);
				fin_lit = !carry;
			end
			ST_CUST: begin
				fin     = 1'b1;
				fin_lit = rd_q[16];
			end
			default: begin
			end
		endcase
	end

	// table ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && opcode == OP_LOAD && led_ok && idx_ok) begin
			mem_we    = 1'b1;
			mem_waddr = {led_ix, idx_ext[POS_W-1:0]};
			mem_wdata = {step_lit, step_duration_ms};
		end
	end

	assign mem_re    = (state_q == ST_EVAL);
	assign mem_raddr = {led_cnt_q, npos};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			time_q      <= '0;
			rcnt_q      <= '0;
			period_q    <= REFRESH_RESET;
			pin_image_q <= PINS_ALL_OFF;
			out_valid_q <= 1'b0;
			pin_byte_q  <= PINS_ALL_OFF;
			led_cnt_q   <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			clr_q       <= '0;
			npos_q      <= '0;
			adv_q       <= 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) begin
				mode_q[i]  <= MODE_OFF;
				blink_q[i] <= '0;
				len_q[i]   <= '0;
				pos_q[i]   <= '0;
				dl_q[i]    <= '0;
			end
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			// the done step posts the next word itself
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			if (fin) begin
				pin_image_q[3'(led_cnt_q)] <= !fin_lit;
				if (last_led) begin
					state_q <= ST_DONE;
				end else begin
					led_cnt_q <= led_cnt_q + 1'b1;
					state_q   <= ST_EVAL;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (opcode)
							OP_TICK: begin
								time_q <= sum_w[31:0];
								if (hit) begin
									rcnt_q    <= '0;
									led_cnt_q <= '0;
									state_q   <= ST_EVAL;
								end else begin
									rcnt_q <= cnt_next[15:0];
								end
							end
							OP_SET: begin
								if (led_ok) begin
									mode_q[led_ix]  <= mode;
									blink_q[led_ix] <= blink_period_ms;
									len_q[led_ix]   <= len_sat[LEN_W-1:0];
									pos_q[led_ix]   <= '0;
									dl_q[led_ix]    <= time_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EVAL: begin
					if (!fin) begin
						if (cur_mode == MODE_BLINK) begin
							rem_q   <= '0;
							bit_q   <= 5'd31;
							state_q <= ST_DIV;
						end else begin
							npos_q  <= npos;
							adv_q   <= carry;
							state_q <= ST_CUST;
						end
					end
				end
				ST_DIV: begin
					rem_q <= carry ? sum_w[14:0] : r_sh[14:0];
					bit_q <= bit_q - 1'b1;
				end
				ST_CUST: begin
					pos_q[led_cnt_q] <= npos_q;
					if (adv_q) begin
						dl_q[led_cnt_q] <= sum_w[31:0];
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						pin_byte_q  <= pin_image_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// unused pins never light
	`LPE_ASSERT_IMP(a_unused_pins_off, 1'b1, (pin_image_q | LOW_MASK) == PINS_ALL_OFF)
	// a word is posted only from the done step
	`LPE_ASSERT_IMP(a_post_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE)
	// divider leaves after its last quotient bit
	`LPE_ASSERT_NXT(a_div_ends, state_q == ST_DIV && bit_q == 5'd0, state_q != ST_DIV)

endmodule

FILE: sim/tb_led_pattern_engine.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_led_pattern_engine
// Drives set, load, tick and unused-opcode words into the LED pattern engine under several
// refresh periods. Bursty input and a stalling output side are used. Every
// posted pin byte is checked against a cycle-free forecast of the LED state.
// ---------------------------------------------------------------------------
module tb_led_pattern_engine;
	import lpe_pkg::*;

	localparam int NUM_LEDS      = 8;
	localparam int MAX_STEPS     = 16;
	localparam int SETTLE_CYCLES = 400;  // outlasts a refresh walk of 8 blink LEDs plus the post
	localparam int LONG_HOLD     = 3000;
	localparam int CYCLE_LIMIT   = 2500000;

	localparam opcode_t OP_UNUSED = 2'd3;

	typedef struct {
		opcode_t  opcode;
		led_t     led;
		mode_t    mode;
		word_t    blink_period_ms;
		seqlen_t  sequence_length;
		stepidx_t step_index;
		logic     step_lit;
		word_t    step_duration_ms;
	} led_word_t;

	typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_style_t;

	// Untimed copy of the LED state; queues the pin byte each refreshing tick.
	class pin_forecast;
		word_t    refresh_period;
		time_t    now_ms;
		word_t    tick_count;
		pins_t    pins;
		mode_t    mode_of[NUM_LEDS];
		word_t    blink_of[NUM_LEDS];
		seqlen_t  len_of[NUM_LEDS];
		stepidx_t pos_of[NUM_LEDS];
		time_t    deadline_of[NUM_LEDS];
		logic     step_lit_of[NUM_LEDS][MAX_STEPS];
		word_t    step_dur_of[NUM_LEDS][MAX_STEPS];
		pins_t    pending[$];
		int       errors;

		function new();
			refresh_period = REFRESH_RESET;
			now_ms = '0;
			tick_count = '0;
			pins = PINS_ALL_OFF;
			errors = 0;
			for (int n = 0; n < NUM_LEDS; n++) begin
				mode_of[n] = MODE_OFF;
				blink_of[n] = '0;
				len_of[n] = '0;
				pos_of[n] = '0;
				deadline_of[n] = '0;
				for (int s = 0; s < MAX_STEPS; s++) begin
					step_lit_of[n][s] = 1'b0;
					step_dur_of[n][s] = '0;
				end
			end
		endfunction

		function bit led_lit(int n);
			time_t       half;
			time_t       quo;
			int unsigned len;
			int unsigned p;
			case (mode_of[n])
				MODE_ON: return 1'b1;
				MODE_BLINK: begin
					half = time_t'(blink_of[n] >> 1);
					if (half == 0)
						return 1'b0;
					quo = now_ms / half;
					return quo[0] == 1'b0;
				end
				MODE_CUSTOM: begin
					len = 32'(len_of[n]);
					if (len == 0)
						return 1'b0;
					p = 32'(pos_of[n]) % len;
					if (now_ms >= deadline_of[n]) begin
						p = (p + 1) % len;
						deadline_of[n] = now_ms + time_t'(step_dur_of[n][p]);
					end
					pos_of[n] = stepidx_t'(p);
					return step_lit_of[n][p];
				end
				default: return 1'b0;
			endcase
		endfunction

		function void apply_word(led_word_t w);
			int unsigned period;
			int unsigned count;
			int unsigned len;
			case (w.opcode)
				OP_TICK: begin
					now_ms = now_ms + 1;
					period = (refresh_period == 0) ? 1 : 32'(refresh_period);
					count = 32'(tick_count) + 1;
					if (count < period)
						tick_count = word_t'(count);
					else begin
						tick_count = '0;
						for (int n = 0; n < NUM_LEDS; n++)
							pins[n] = ~led_lit(n);
						pending.push_back(pins);
					end
				end
				OP_SET: begin
					len = 32'(w.sequence_length);
					if (len > MAX_STEPS)
						len = MAX_STEPS;
					mode_of[w.led] = w.mode;
					blink_of[w.led] = w.blink_period_ms;
					len_of[w.led] = seqlen_t'(len);
					pos_of[w.led] = '0;
					deadline_of[w.led] = now_ms;
				end
				OP_LOAD: begin
					step_lit_of[w.led][w.step_index] = w.step_lit;
					step_dur_of[w.led][w.step_index] = w.step_duration_ms;
				end
				default: ;
			endcase
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR @%0t: %s", $realtime, msg);
		endfunction

		function void check_pins(pins_t got);
			pins_t want;
			if (pending.size() == 0) begin
				note_error($sformatf("pin byte %h posted with none expected", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				note_error($sformatf("pin_byte expected %h got %h", want, got));
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	word_t    cfg_data;
	logic     in_valid;
	logic     in_ready;
	opcode_t  opcode;
	led_t     led;
	mode_t    mode;
	word_t    blink_period_ms;
	seqlen_t  sequence_length;
	stepidx_t step_index;
	logic     step_lit;
	word_t    step_duration_ms;
	logic     out_valid;
	logic     out_ready;
	pins_t    pin_byte;

	pin_forecast forecast = new();
	int          burst_left = 0;
	int          words_sent = 0;
	bit          hold_request = 1'b0;

	led_pattern_engine #(
		.NUM_LEDS (NUM_LEDS),
		.MAX_STEPS(MAX_STEPS)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.led             (led),
		.mode            (mode),
		.blink_period_ms (blink_period_ms),
		.sequence_length (sequence_length),
		.step_index      (step_index),
		.step_lit        (step_lit),
		.step_duration_ms(step_duration_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pin_byte        (pin_byte)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// output side: random styles over random spans, plus one long hold-off on request
	initial begin
		rx_style_t style;
		int        span;
		int        hold;
		out_ready <= 1'b0;
		style = RX_FREE;
		span = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold = LONG_HOLD;
			end
			if (span == 0) begin
				style = rx_style_t'($urandom_range(0, 3));
				span = $urandom_range(20, 300);
			end
			span--;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (style)
					RX_FREE:   out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (span % 5 != 0);
				endcase
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			forecast.check_pins(pin_byte);

	function automatic led_word_t make_word(opcode_t op, led_t l, mode_t m, word_t bp,
		seqlen_t len, stepidx_t idx, logic lit, word_t dur);
		led_word_t w;
		w.opcode = op;
		w.led = l;
		w.mode = m;
		w.blink_period_ms = bp;
		w.sequence_length = len;
		w.step_index = idx;
		w.step_lit = lit;
		w.step_duration_ms = dur;
		return w;
	endfunction

	function automatic word_t pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return word_t'($urandom_range(0, 16));
		if (r < 85)
			return word_t'($urandom_range(0, 2000));
		return word_t'($urandom);
	endfunction

	function automatic word_t pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return word_t'($urandom_range(0, 6));
		if (r < 90)
			return word_t'($urandom_range(0, 200));
		return word_t'($urandom);
	endfunction

	function automatic led_word_t noise_word(opcode_t op);
		return make_word(op, led_t'($urandom), mode_t'($urandom), pick_period(),
			seqlen_t'($urandom), stepidx_t'($urandom), 1'($urandom), pick_duration());
	endfunction

	task automatic send_word(led_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= w.opcode;
		led <= w.led;
		mode <= w.mode;
		blink_period_ms <= w.blink_period_ms;
		sequence_length <= w.sequence_length;
		step_index <= w.step_index;
		step_lit <= w.step_lit;
		step_duration_ms <= w.step_duration_ms;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		forecast.apply_word(w);
		if (w.opcode != OP_UNUSED)
			words_sent++;
	endtask

	// well-formed custom pattern: fill the step table for one LED, then select it
	task automatic send_sequence();
		led_word_t   w;
		int unsigned n_steps;
		led_t        target;
		target = led_t'($urandom_range(0, NUM_LEDS - 1));
		n_steps = $urandom_range(1, MAX_STEPS);
		for (int k = 0; k < n_steps; k++) begin
			w = noise_word(OP_LOAD);
			w.led = target;
			w.step_index = stepidx_t'(k);
			send_word(w);
		end
		w = noise_word(OP_SET);
		w.led = target;
		w.mode = MODE_CUSTOM;
		if ($urandom_range(0, 9) != 0)
			w.sequence_length = seqlen_t'(n_steps);
		send_word(w);
	endtask

	task automatic run_mix(int count);
		int r;
		int goal;
		goal = words_sent + count;
		while (words_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				send_sequence();
			else if (r < 20)
				send_word(noise_word(OP_SET));
			else if (r < 30)
				send_word(noise_word(OP_LOAD));
			else if (r < 33)
				send_word(noise_word(OP_UNUSED));
			else
				repeat ($urandom_range(1, 12)) send_word(noise_word(OP_TICK));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (forecast.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_refresh(word_t value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		forecast.refresh_period = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_TICK;
		led <= '0;
		mode <= MODE_OFF;
		blink_period_ms <= '0;
		sequence_length <= '0;
		step_index <= '0;
		step_lit <= 1'b0;
		step_duration_ms <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under the reset refresh period
		send_word(make_word(OP_LOAD, 3'd0, MODE_OFF, 16'd0, 5'd0, 4'd0, 1'b1, 16'd0));
		send_word(make_word(OP_LOAD, 3'd0, MODE_OFF, 16'd0, 5'd0, 4'd15, 1'b0, 16'hFFFF));
		send_word(make_word(OP_LOAD, 3'd7, MODE_OFF, 16'd0, 5'd0, 4'd0, 1'b1, 16'hFFFF));
		send_word(make_word(OP_LOAD, 3'd7, MODE_OFF, 16'd0, 5'd0, 4'd1, 1'b0, 16'd1));
		send_word(make_word(OP_LOAD, 3'd6, MODE_OFF, 16'd0, 5'd0, 4'd3, 1'b1, 16'd2));
		send_word(make_word(OP_SET, 3'd0, MODE_ON, 16'd0, 5'd0, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_SET, 3'd1, MODE_OFF, 16'hFFFF, 5'd31, 4'd15, 1'b1, 16'hFFFF));
		// blink half periods of zero stay dark; a period of two gives a half period of one
		send_word(make_word(OP_SET, 3'd2, MODE_BLINK, 16'd0, 5'd0, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_SET, 3'd3, MODE_BLINK, 16'd1, 5'd0, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_SET, 3'd4, MODE_BLINK, 16'd2, 5'd0, 4'd0, 1'b0, 16'd0));
		// empty sequence, oversized sequence, two-step sequence
		send_word(make_word(OP_SET, 3'd5, MODE_CUSTOM, 16'd0, 5'd0, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_SET, 3'd6, MODE_CUSTOM, 16'd0, 5'd31, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_SET, 3'd7, MODE_CUSTOM, 16'hFFFF, 5'd2, 4'd0, 1'b0, 16'd0));
		send_word(make_word(OP_UNUSED, 3'd7, MODE_CUSTOM, 16'hFFFF, 5'd31, 4'd15, 1'b1,
			16'hFFFF));
		repeat (110) send_word(make_word(OP_TICK, 3'd0, MODE_OFF, 16'd0, 5'd0, 4'd0, 1'b0,
			16'd0));
		settle();

		// zero period acts as one; long output hold-off backs up the input
		write_refresh(16'd0);
		hold_request = 1'b1;
		run_mix(250);
		settle();

		write_refresh(16'd1);
		run_mix(300);
		settle();

		// max period: counter only climbs, then a short period fires at once
		write_refresh(16'hFFFF);
		run_mix(150);
		settle();

		write_refresh(word_t'($urandom_range(2, 12)));
		run_mix(400);
		settle();

		write_refresh(16'd3);
		run_mix(200);
		settle();

		write_refresh(16'd1);
		run_mix(100);
		settle();

		if (forecast.errors == 0 && forecast.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
